// File: design/rdc_pkg.sv
// ============================================================================
// rdc_pkg
// Shared types and constants of the range distinct-count core: the request
// and response words, request codes, status codes and storage sizes.
// ============================================================================
package rdc_pkg;

    // Array and value sizing.
    localparam int MAX_ELEMS   = 4096;
    localparam int VALUE_BITS  = 16;
    localparam int ELEM_AW     = $clog2(MAX_ELEMS);
    localparam int POS_W       = ELEM_AW + 1;
    localparam int HIST_DEPTH  = 1 << VALUE_BITS;
    localparam int HCNT_W      = POS_W + 1;

    // Fixed field widths of the words.
    localparam int IDX_W   = 12;
    localparam int VAL_W   = 16;
    localparam int CNT_W   = 13;

    // Request codes.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Status codes.
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_RANGE = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [IDX_W-1:0] elem_index;
        logic [VAL_W-1:0] elem_value;
        logic [IDX_W-1:0] range_left;
        logic [IDX_W-1:0] range_right;
    } rdc_req_t;

    typedef struct packed {
        logic [CNT_W-1:0] distinct_count;
        logic             status;
    } rdc_rsp_t;

endpackage

// File: design/rdc_ram.sv
// ============================================================================
// rdc_ram
// Generic single-port RAM with registered read data. A write cycle does not
// update the read data.
// ============================================================================
module rdc_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 4096,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        else
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/range_distinct_count_core.sv
// ============================================================================
// range_distinct_count_core
// Distinct-value counter over ranges of a loaded element array, using a
// sliding window, a per-value count histogram and a running distinct total.
// ============================================================================
// Sequence: a load outside the window runs ST_DISPATCH and ST_LDWR; a load
// inside the window adds ST_ERD, ST_HRD, ST_HWR (drop) and ST_HRD, ST_HWR
// (add) before ST_LDWR. A query runs ST_DISPATCH and ST_PLAN, then ST_ERD,
// ST_HRD, ST_HWR, ST_PLAN once per position the window moves, then ST_DONE;
// each move is one read-modify-write of the histogram through its single RAM
// port. A rejected range goes straight from ST_DISPATCH to ST_DONE.
// Throughput: one word at a time; in_ready is low while a word is processed.
// Reset: rst_n resets all control state (elem_count to MAX_ELEMS), then the
// histogram is cleared one entry per cycle; no word is accepted meanwhile.
// ============================================================================
module range_distinct_count_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  rdc_pkg::rdc_req_t       in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output rdc_pkg::rdc_rsp_t       out_data,
    input  logic                    cfg_wr_en,
    input  logic [rdc_pkg::CNT_W-1:0] cfg_wr_data
);

    import rdc_pkg::*;

    // Sequencer states. Each window move runs ST_PLAN, ST_ERD, ST_HRD, ST_HWR
    // once; an in-window load drops via the last three, adds via the last two.
    typedef enum logic [8:0] {
        ST_CLEAR    = 9'b000000001,
        ST_IDLE     = 9'b000000010,
        ST_DISPATCH = 9'b000000100,
        ST_PLAN     = 9'b000001000,
        ST_ERD      = 9'b000010000,
        ST_HRD      = 9'b000100000,
        ST_HWR      = 9'b001000000,
        ST_LDWR     = 9'b010000000,
        ST_DONE     = 9'b100000000
    } state_t;

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_ELEMS);

    state_t                  state_reg, state_next;
    logic [POS_W-1:0]        win_start_reg, win_start_next;
    logic [POS_W-1:0]        win_end_reg, win_end_next;
    logic [CNT_W-1:0]        total_reg, total_next;
    logic [CNT_W-1:0]        elem_count_reg, elem_count_next;
    logic [VALUE_BITS-1:0]   clr_addr_reg, clr_addr_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    step_add_reg, step_add_next;
    logic                    ld_add_reg, ld_add_next;
    logic                    bad_reg, bad_next;

    rdc_req_t                req_reg, req_next;
    logic [ELEM_AW-1:0]      step_idx_reg, step_idx_next;
    logic [VALUE_BITS-1:0]   val_reg, val_next;
    rdc_rsp_t                out_data_reg, out_data_next;

    // Element store port.
    logic                    e_we;
    logic [ELEM_AW-1:0]      e_addr;
    logic [VALUE_BITS-1:0]   e_wdata;
    logic [VALUE_BITS-1:0]   e_rdata;

    // Histogram port.
    logic                    h_we;
    logic [VALUE_BITS-1:0]   h_addr;
    logic [HCNT_W-1:0]       h_wdata;
    logic [HCNT_W-1:0]       h_rdata;

    // Decoded request and window quantities.
    logic [POS_W-1:0]        limit;
    logic [POS_W-1:0]        lb_ext;
    logic [POS_W-1:0]        rb_ext;
    logic [POS_W-1:0]        rb_plus1;
    logic [POS_W-1:0]        idx_ext;
    logic                    in_window;
    logic                    load_add;
    logic [VALUE_BITS-1:0]   hist_val;
    logic signed [HCNT_W-1:0] cnt_old;
    logic signed [HCNT_W-1:0] cnt_new;

    rdc_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_ELEMS)
    ) u_elem_ram (
        .clk   (clk),
        .we    (e_we),
        .addr  (e_addr),
        .wdata (e_wdata),
        .rdata (e_rdata)
    );

    rdc_ram #(
        .WIDTH (HCNT_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (h_we),
        .addr  (h_addr),
        .wdata (h_wdata),
        .rdata (h_rdata)
    );

    // An elem_count above the array size acts as the array size.
    assign limit     = (elem_count_reg > MAX_POS) ? MAX_POS : elem_count_reg;
    assign lb_ext    = POS_W'(req_reg.range_left);
    assign rb_ext    = POS_W'(req_reg.range_right);
    assign rb_plus1  = rb_ext + POS_W'(1);
    assign idx_ext   = POS_W'(req_reg.elem_index);
    assign in_window = (idx_ext >= win_start_reg) && (idx_ext < win_end_reg);

    // During the add step of a load the value comes from the request, not
    // from the element store.
    assign load_add  = (req_reg.req_type == REQ_LOAD) && ld_add_reg;
    assign hist_val  = load_add ? req_reg.elem_value[VALUE_BITS-1:0] : e_rdata;

    // The shared counter unit: counts are signed and may dip below zero
    // while the window end passes below its start.
    assign cnt_old   = $signed(h_rdata);
    assign cnt_new   = step_add_reg ? (cnt_old + HCNT_W'(1)) : (cnt_old - HCNT_W'(1));

    always_comb
    begin
        state_next      = state_reg;
        win_start_next  = win_start_reg;
        win_end_next    = win_end_reg;
        total_next      = total_reg;
        elem_count_next = elem_count_reg;
        clr_addr_next   = clr_addr_reg;
        out_valid_next  = out_valid_reg;
        step_add_next   = step_add_reg;
        ld_add_next     = ld_add_reg;
        bad_next        = bad_reg;
        req_next        = req_reg;
        step_idx_next   = step_idx_reg;
        val_next        = val_reg;
        out_data_next   = out_data_reg;

        e_we    = 1'b0;
        e_addr  = step_idx_reg;
        e_wdata = req_reg.elem_value[VALUE_BITS-1:0];
        h_we    = 1'b0;
        h_addr  = val_reg;
        h_wdata = cnt_new;

        if (cfg_wr_en)
        begin
            elem_count_next = cfg_wr_data;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                h_we          = 1'b1;
                h_addr        = clr_addr_reg;
                h_wdata       = '0;
                clr_addr_next = clr_addr_reg + VALUE_BITS'(1);
                if (clr_addr_reg == {VALUE_BITS{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = in_data;
                    state_next = ST_DISPATCH;
                end
            end

            ST_DISPATCH:
            begin
                if (req_reg.req_type == REQ_LOAD)
                begin
                    // A load inside the window first drops the old value.
                    if (in_window)
                    begin
                        step_idx_next = req_reg.elem_index[ELEM_AW-1:0];
                        step_add_next = 1'b0;
                        ld_add_next   = 1'b0;
                        state_next    = ST_ERD;
                    end
                    else
                    begin
                        state_next = ST_LDWR;
                    end
                end
                else if ((lb_ext > rb_ext) || (rb_ext >= limit))
                begin
                    bad_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    bad_next   = 1'b0;
                    ld_add_next = 1'b0;
                    state_next = ST_PLAN;
                end
            end

            ST_PLAN:
            begin
                // Move order: extend right, shrink right, shrink left,
                // extend left; one position per pass.
                if (win_end_reg <= rb_ext)
                begin
                    step_idx_next = win_end_reg[ELEM_AW-1:0];
                    step_add_next = 1'b1;
                    win_end_next  = win_end_reg + POS_W'(1);
                    state_next    = ST_ERD;
                end
                else if (win_end_reg > rb_plus1)
                begin
                    step_idx_next = ELEM_AW'(win_end_reg - POS_W'(1));
                    step_add_next = 1'b0;
                    win_end_next  = win_end_reg - POS_W'(1);
                    state_next    = ST_ERD;
                end
                else if (win_start_reg < lb_ext)
                begin
                    step_idx_next  = win_start_reg[ELEM_AW-1:0];
                    step_add_next  = 1'b0;
                    win_start_next = win_start_reg + POS_W'(1);
                    state_next     = ST_ERD;
                end
                else if (win_start_reg > lb_ext)
                begin
                    step_idx_next  = ELEM_AW'(win_start_reg - POS_W'(1));
                    step_add_next  = 1'b1;
                    win_start_next = win_start_reg - POS_W'(1);
                    state_next     = ST_ERD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_ERD:
            begin
                e_addr     = step_idx_reg;
                state_next = ST_HRD;
            end

            ST_HRD:
            begin
                h_addr     = hist_val;
                val_next   = hist_val;
                state_next = ST_HWR;
            end

            ST_HWR:
            begin
                h_we    = 1'b1;
                h_addr  = val_reg;
                h_wdata = cnt_new;
                if (step_add_reg && (cnt_new == HCNT_W'(1)))
                begin
                    total_next = total_reg + CNT_W'(1);
                end
                else if (!step_add_reg && (cnt_new == '0))
                begin
                    total_next = total_reg - CNT_W'(1);
                end

                if (req_reg.req_type == REQ_QUERY)
                begin
                    state_next = ST_PLAN;
                end
                else if (!ld_add_reg)
                begin
                    ld_add_next   = 1'b1;
                    step_add_next = 1'b1;
                    state_next    = ST_HRD;
                end
                else
                begin
                    state_next = ST_LDWR;
                end
            end

            ST_LDWR:
            begin
                e_we       = 1'b1;
                e_addr     = req_reg.elem_index[ELEM_AW-1:0];
                state_next = ST_IDLE;
            end

            ST_DONE:
            begin
                // Hold here only while an earlier result is still unclaimed.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.distinct_count = bad_reg ? '0 : total_reg;
                    out_data_next.status         = bad_reg ? STATUS_BAD_RANGE : STATUS_OK;
                    state_next                   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            win_start_reg  <= '0;
            win_end_reg    <= '0;
            total_reg      <= '0;
            elem_count_reg <= CNT_W'(MAX_ELEMS);
            clr_addr_reg   <= '0;
            out_valid_reg  <= 1'b0;
            step_add_reg   <= 1'b0;
            ld_add_reg     <= 1'b0;
            bad_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            win_start_reg  <= win_start_next;
            win_end_reg    <= win_end_next;
            total_reg      <= total_next;
            elem_count_reg <= elem_count_next;
            clr_addr_reg   <= clr_addr_next;
            out_valid_reg  <= out_valid_next;
            step_add_reg   <= step_add_next;
            ld_add_reg     <= ld_add_next;
            bad_reg        <= bad_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        step_idx_reg <= step_idx_next;
        val_reg      <= val_next;
        out_data_reg <= out_data_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: design/rdc_checker.sv
// ============================================================================
// rdc_checker
// Port-level checks for the range distinct-count core, bound to its top.
// ============================================================================
module rdc_checker (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  rdc_pkg::rdc_rsp_t       out_data
);

    import rdc_pkg::*;

    // A result word waiting for its sink holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

    // A rejected range always reports a count of zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == STATUS_BAD_RANGE) |-> out_data.distinct_count == '0)
    else $error("bad range reported a nonzero count");

    // An accept moves the core out of ST_IDLE, so an accept is never followed by
    // another accept in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("ready right after an accept");

    // The histogram clearing pass keeps the input closed after reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !in_ready)
    else $error("ready during the clearing pass");

endmodule

bind range_distinct_count_core rdc_checker u_rdc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
